// ----- rtl/core/csvp_pkg.sv -----
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared types, constants and small tables of the CSV price bar row parser.
// ----------------------------------------------------------------------------
package csvp_pkg;

    localparam int FRACTION_DIGITS = 6;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [64:0] TOP64 = 65'h0_8000_0000_0000_0000;

    // serial units: four bits a step
    localparam logic [3:0] MUL_LAST = 4'd14;   // 60-bit scale, 15 nibbles
    localparam logic [3:0] DIV_LAST = 4'd15;   // 64-bit value, 16 nibbles
    localparam logic [2:0] DATE_LAST = 3'd4;

    localparam logic [12:0] YEAR_RECIP   = 13'd5243;  // 2^21 / 400, rounded up
    localparam int          YEAR_SHIFT   = 21;
    localparam logic [5:0]  CENT_RECIP   = 6'd41;     // 2^12 / 100, rounded up
    localparam int          CENT_SHIFT   = 12;
    localparam logic [7:0]  TEN_RECIP    = 8'd205;    // 2^11 / 10, rounded up
    localparam int          TEN_SHIFT    = 11;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
    localparam logic [31:0] DAYS_PER_ERA = 32'd146097;
    localparam logic [31:0] EPOCH_DAYS   = 32'd719468;
    localparam logic [63:0] SEC_PER_DAY  = 64'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [11:0] SEC_PER_MIN  = 12'd60;

    localparam logic [7:0] CFG_TS_SCALE    = 8'd0;
    localparam logic [7:0] CFG_VOL_SCALE   = 8'd1;
    localparam logic [7:0] CFG_PRICE_SCALE = 8'd2;
    localparam logic [7:0] CFG_SKIP_HEADER = 8'd3;

    typedef enum logic [3:0] {
        CH_DIGIT,
        CH_DOT,
        CH_MINUS,
        CH_PLUS,
        CH_COMMA,
        CH_COLON,
        CH_SPACE,
        CH_NEWLINE,
        CH_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        eod;
    } token_t;

    typedef struct packed {
        logic [39:0] ts_scale;
        logic [59:0] vol_scale;
        logic [59:0] price_scale;
        logic        skip_header;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONSUME,
        ST_DIV,
        ST_DATE,
        ST_FRAC,
        ST_MUL,
        ST_FINISH,
        ST_CLOSE,
        ST_CLOSE2
    } back_state_t;

    typedef enum logic [1:0] {
        FIN_STAMP,
        FIN_PRICE,
        FIN_VOL
    } fin_kind_t;

    localparam logic [1:0] MODE_NUMBER = 2'd0;
    localparam logic [1:0] MODE_DATE   = 2'd1;
    localparam logic [1:0] MODE_FRAC   = 2'd2;
    localparam logic [1:0] MODE_ZONE   = 2'd3;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        if (c >= 8'h30 && c <= 8'h39) r = CH_DIGIT;
        else if (c == 8'h2E) r = CH_DOT;
        else if (c == 8'h2D) r = CH_MINUS;
        else if (c == 8'h2B) r = CH_PLUS;
        else if (c == 8'h2C) r = CH_COMMA;
        else if (c == 8'h3A) r = CH_COLON;
        else if (c == 8'h20) r = CH_SPACE;
        else if (c == 8'h0A) r = CH_NEWLINE;
        else r = CH_OTHER;
        return r;
    endfunction

    function automatic logic [63:0] pow10(input logic [3:0] n);
        logic [63:0] r;
        case (n)
            4'd0: r = 64'd1;
            4'd1: r = 64'd10;
            4'd2: r = 64'd100;
            4'd3: r = 64'd1000;
            4'd4: r = 64'd10000;
            4'd5: r = 64'd100000;
            4'd6: r = 64'd1000000;
            4'd7: r = 64'd10000000;
            4'd8: r = 64'd100000000;
            4'd9: r = 64'd1000000000;
            default: r = 64'd1;
        endcase
        return r;
    endfunction

    // day of a march-based year at which each month starts
    function automatic logic [8:0] doy_base(input logic [3:0] month);
        logic [8:0] r;
        case (month)
            4'd3:  r = 9'd0;
            4'd4:  r = 9'd31;
            4'd5:  r = 9'd61;
            4'd6:  r = 9'd92;
            4'd7:  r = 9'd122;
            4'd8:  r = 9'd153;
            4'd9:  r = 9'd184;
            4'd10: r = 9'd214;
            4'd11: r = 9'd245;
            4'd12: r = 9'd275;
            4'd1:  r = 9'd306;
            4'd2:  r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/csvp_if.sv -----
// ----------------------------------------------------------------------------
// csvp_if
// Channel interfaces of the CSV price bar row parser: text, bars, config.
// ----------------------------------------------------------------------------
interface csvp_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_data;

    modport source (output valid, char_code, end_of_data, input ready);
    modport sink (input valid, char_code, end_of_data, output ready);
endinterface

interface csvp_bar_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] stamp;
    logic [62:0]        open_price;
    logic [62:0]        high_price;
    logic [62:0]        low_price;
    logic [62:0]        close_price;
    logic [62:0]        volume_amount;

    modport source (output valid, stamp, open_price, high_price, low_price, close_price,
                    volume_amount, input ready);
    modport sink (input valid, stamp, open_price, high_price, low_price, close_price,
                  volume_amount, output ready);
endinterface

interface csvp_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/csvp_front.sv -----
// ----------------------------------------------------------------------------
// csvp_front
// Takes text bytes and classifies each into a token for the queue.
// ----------------------------------------------------------------------------
module csvp_front
(
    input  logic              clk,
    input  logic              rst_n,
    csvp_text_if.sink         text,
    output logic              tok_valid,
    output csvp_pkg::token_t  tok,
    input  logic              q_full
);

    logic              tok_valid_reg;
    logic              tok_valid_next;
    csvp_pkg::token_t  tok_reg;
    logic              push;
    logic              take;

    assign push       = tok_valid_reg && !q_full;
    assign text.ready = !tok_valid_reg || !q_full;
    assign take       = text.valid && text.ready;

    always_comb
    begin
        tok_valid_next = tok_valid_reg;
        if (push)
        begin
            tok_valid_next = 1'b0;
        end
        if (take)
        begin
            tok_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg.cls   <= csvp_pkg::classify(text.char_code);
            tok_reg.digit <= text.char_code[3:0];
            tok_reg.eod   <= text.end_of_data;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

// ----- rtl/core/csvp_queue.sv -----
// ----------------------------------------------------------------------------
// csvp_queue
// Short token queue between the classifier and the parse engine.
// ----------------------------------------------------------------------------
module csvp_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  csvp_pkg::token_t  push_tok,
    output logic              full,
    input  logic              pop,
    output csvp_pkg::token_t  head,
    output logic              empty
);

    csvp_pkg::token_t                 mem [csvp_pkg::QUEUE_DEPTH];
    logic [csvp_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [csvp_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [csvp_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [csvp_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [csvp_pkg::QPTR_W:0]        count_reg;
    logic [csvp_pkg::QPTR_W:0]        count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full    = (count_reg == (csvp_pkg::QPTR_W+1)'(csvp_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == csvp_pkg::QPTR_W'(csvp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == csvp_pkg::QPTR_W'(csvp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// ----- rtl/core/csvp_back.sv -----
// ----------------------------------------------------------------------------
// csvp_back
// Parse engine: walks the field grammar token by token, converts numbers to
// fixed point with serial multiply and divide units, and emits whole rows.
// ----------------------------------------------------------------------------
module csvp_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  csvp_pkg::cfg_t    cfg,
    input  logic              hdr_load,
    input  logic              hdr_value,
    input  csvp_pkg::token_t  head,
    input  logic              q_empty,
    output logic              pop,
    csvp_bar_if.source        bar
);

    csvp_pkg::back_state_t state_reg, state_next;
    csvp_pkg::token_t      tok_reg, tok_next;
    csvp_pkg::fin_kind_t   kind_reg, kind_next;

    logic        in_header_reg, in_header_next;
    logic [2:0]  field_reg, field_next;
    logic [4:0]  pos_reg, pos_next;
    logic [1:0]  mode_reg, mode_next;
    logic [63:0] whole_reg, whole_next;
    logic [63:0] frac_reg, frac_next;
    logic [63:0] pv_reg, pv_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [13:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [2:0]  parsed_reg, parsed_next;
    logic        failed_reg, failed_next;
    logic        closing_reg, closing_next;
    logic [63:0] store_reg [6];
    logic        store_we;
    logic [63:0] store_val;

    logic [63:0] mul_a_reg, mul_a_next;
    logic [59:0] mul_b_reg, mul_b_next;
    logic [69:0] acc_reg, acc_next;
    logic        big_reg, big_next;
    logic [3:0]  step_reg, step_next;
    logic [63:0] fadd_reg, fadd_next;
    logic        neg_reg, neg_next;
    logic [3:0]  div_r_reg, div_r_next;
    logic [63:0] div_n_reg, div_n_next;
    logic [63:0] div_q_reg, div_q_next;

    logic [4:0]  era_q_reg, era_q_next;
    logic [8:0]  yoe_reg, yoe_next;
    logic [17:0] doe_reg, doe_next;
    logic [31:0] days_reg, days_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_stamp_reg;
    logic [62:0] out_price_reg [4];
    logic [62:0] out_vol_reg;
    logic        load_out;

    // working values
    logic        is_digit;
    logic        tok_close;
    logic [3:0]  d;
    logic [67:0] wide;
    logic        push_ok;
    logic [4:0]  pos_bump;
    logic        start_fld;
    logic [2:0]  start_fld_num;
    logic        start_line;
    logic        date_ok;
    logic        emit;
    logic [63:0] fr;
    logic [11:0] fr_weight;
    logic [7:0]  t8;
    logic [15:0] t_mul;
    logic [3:0]  qd;
    logic [63:0] quo;
    logic [67:0] dq_mul;
    logic [14:0] yy;
    logic [27:0] yy_mul;
    logic [13:0] cent_mul;
    logic [17:0] doe_sum;
    logic [31:0] era;
    logic [63:0] pw;
    logic [59:0] frac_scaled;
    logic [65:0] prod;
    logic [64:0] lim;
    logic [66:0] psum;
    logic [63:0] res;
    logic        fin_ok;
    logic [69:0] part;

    assign is_digit  = (tok_reg.cls == csvp_pkg::CH_DIGIT);
    assign tok_close = (tok_reg.cls == csvp_pkg::CH_NEWLINE) || tok_reg.eod;
    assign d         = tok_reg.digit;
    assign wide      = ({4'b0, whole_reg} << 3) + ({4'b0, whole_reg} << 1) + {64'b0, d};
    assign push_ok   = (wide <= {4'b0, csvp_pkg::MAX63});
    assign pos_bump  = (pos_reg < 5'd31) ? pos_reg + 5'd1 : pos_reg;
    assign emit      = !failed_reg && (field_reg == 3'd6) && (parsed_reg == 3'd6);

    always_comb
    begin
        state_next     = state_reg;
        tok_next       = tok_reg;
        kind_next      = kind_reg;
        in_header_next = in_header_reg;
        field_next     = field_reg;
        pos_next       = pos_reg;
        mode_next      = mode_reg;
        whole_next     = whole_reg;
        frac_next      = frac_reg;
        pv_next        = pv_reg;
        cnt_next       = cnt_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        parsed_next    = parsed_reg;
        failed_next    = failed_reg;
        closing_next   = closing_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        acc_next       = acc_reg;
        big_next       = big_reg;
        step_next      = step_reg;
        fadd_next      = fadd_reg;
        neg_next       = neg_reg;
        div_r_next     = div_r_reg;
        div_n_next     = div_n_reg;
        div_q_next     = div_q_reg;
        era_q_next     = era_q_reg;
        yoe_next       = yoe_reg;
        doe_next       = doe_reg;
        days_next      = days_reg;
        store_we       = 1'b0;
        store_val      = 64'd0;
        load_out       = 1'b0;
        pop            = 1'b0;
        start_fld      = 1'b0;
        start_fld_num  = 3'd0;
        start_line     = 1'b0;
        date_ok        = 1'b0;
        fr             = 64'd0;
        fr_weight      = 12'd0;
        t8             = 8'd0;
        t_mul          = 16'd0;
        qd             = 4'd0;
        quo            = 64'd0;
        dq_mul         = 68'd0;
        yy             = 15'd0;
        yy_mul         = 28'd0;
        cent_mul       = 14'd0;
        doe_sum        = 18'd0;
        era            = 32'd0;
        pw             = 64'd0;
        frac_scaled    = 60'd0;
        prod           = 66'd0;
        lim            = 65'd0;
        psum           = 67'd0;
        res            = 64'd0;
        fin_ok         = 1'b0;
        part           = 70'd0;

        case (state_reg)
            csvp_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    tok_next   = head;
                    state_next = csvp_pkg::ST_CONSUME;
                end
            end

            csvp_pkg::ST_CONSUME:
            begin
                state_next = tok_close ? csvp_pkg::ST_CLOSE : csvp_pkg::ST_IDLE;
                if (tok_reg.cls != csvp_pkg::CH_NEWLINE && !in_header_reg && !failed_reg
                    && field_reg < 3'd6)
                begin
                    if (field_reg == 3'd5)
                    begin
                        if (is_digit || (tok_reg.cls == csvp_pkg::CH_DOT
                                         && mode_reg == csvp_pkg::MODE_NUMBER))
                        begin
                            if (tok_reg.cls == csvp_pkg::CH_DOT)
                            begin
                                mode_next = csvp_pkg::MODE_FRAC;
                                pos_next  = pos_bump;
                            end
                            else if (mode_reg == csvp_pkg::MODE_NUMBER)
                            begin
                                if (push_ok)
                                begin
                                    whole_next = wide[63:0];
                                    pos_next   = pos_bump;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                end
                            end
                            else
                            begin
                                div_n_next = pv_reg;
                                div_r_next = 4'd0;
                                div_q_next = 64'd0;
                                step_next  = 4'd0;
                                state_next = csvp_pkg::ST_DIV;
                            end
                        end
                        else if (pos_reg == 5'd0)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            // volume ends here, rest of the line is ignored
                            mul_a_next = whole_reg;
                            mul_b_next = cfg.vol_scale;
                            fadd_next  = frac_reg;
                            kind_next  = csvp_pkg::FIN_VOL;
                            acc_next   = 70'd0;
                            big_next   = 1'b0;
                            step_next  = 4'd0;
                            state_next = csvp_pkg::ST_MUL;
                        end
                    end
                    else if (tok_reg.cls == csvp_pkg::CH_COMMA)
                    begin
                        if (field_reg == 3'd0)
                        begin
                            if (pos_reg == 5'd0
                                || (mode_reg == csvp_pkg::MODE_DATE && pos_reg != 5'd10
                                    && pos_reg != 5'd19)
                                || (mode_reg == csvp_pkg::MODE_ZONE && pv_reg != 64'd6))
                            begin
                                failed_next = 1'b1;
                            end
                            else
                            begin
                                state_next = csvp_pkg::ST_FRAC;
                            end
                        end
                        else if (pos_reg == 5'd0)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            mul_a_next = whole_reg;
                            mul_b_next = cfg.price_scale;
                            fadd_next  = frac_reg;
                            kind_next  = csvp_pkg::FIN_PRICE;
                            acc_next   = 70'd0;
                            big_next   = 1'b0;
                            step_next  = 4'd0;
                            state_next = csvp_pkg::ST_MUL;
                        end
                    end
                    else if (field_reg == 3'd0)
                    begin
                        // timestamp grammar
                        failed_next = 1'b1;
                        if (mode_reg == csvp_pkg::MODE_NUMBER)
                        begin
                            if (is_digit)
                            begin
                                if (push_ok)
                                begin
                                    whole_next  = wide[63:0];
                                    failed_next = 1'b0;
                                end
                            end
                            else if (tok_reg.cls == csvp_pkg::CH_DOT)
                            begin
                                mode_next   = csvp_pkg::MODE_FRAC;
                                failed_next = 1'b0;
                            end
                            else if (tok_reg.cls == csvp_pkg::CH_MINUS && pos_reg == 5'd4)
                            begin
                                year_next   = whole_reg[13:0];
                                whole_next  = 64'd0;
                                mode_next   = csvp_pkg::MODE_DATE;
                                failed_next = 1'b0;
                            end
                        end
                        else if (mode_reg == csvp_pkg::MODE_DATE)
                        begin
                            case (pos_reg)
                                5'd5, 5'd6, 5'd8, 5'd9:
                                begin
                                    if (is_digit)
                                    begin
                                        whole_next  = wide[63:0];
                                        failed_next = 1'b0;
                                        if (pos_reg == 5'd9)
                                        begin
                                            if (wide < 68'd1 || wide > 68'd31)
                                            begin
                                                failed_next = 1'b1;
                                            end
                                            else
                                            begin
                                                day_next   = wide[4:0];
                                                step_next  = 4'd0;
                                                state_next = csvp_pkg::ST_DATE;
                                            end
                                        end
                                    end
                                end
                                5'd7:
                                begin
                                    if (tok_reg.cls == csvp_pkg::CH_MINUS
                                        && whole_reg >= 64'd1 && whole_reg <= 64'd12)
                                    begin
                                        month_next  = whole_reg[3:0];
                                        whole_next  = 64'd0;
                                        failed_next = 1'b0;
                                    end
                                end
                                5'd10, 5'd19:
                                begin
                                    if (pos_reg == 5'd10 && tok_reg.cls == csvp_pkg::CH_SPACE)
                                    begin
                                        failed_next = 1'b0;
                                    end
                                    else if (tok_reg.cls == csvp_pkg::CH_DOT)
                                    begin
                                        mode_next   = csvp_pkg::MODE_FRAC;
                                        failed_next = 1'b0;
                                    end
                                    else if (tok_reg.cls == csvp_pkg::CH_PLUS
                                             || tok_reg.cls == csvp_pkg::CH_MINUS)
                                    begin
                                        mode_next   = csvp_pkg::MODE_ZONE;
                                        pv_next     = 64'd1;
                                        failed_next = 1'b0;
                                    end
                                end
                                5'd11, 5'd12, 5'd14, 5'd15, 5'd17, 5'd18:
                                begin
                                    if (is_digit)
                                    begin
                                        failed_next = 1'b0;
                                        fr = (frac_reg << 3) + (frac_reg << 1) + {60'd0, d};
                                        if (pos_reg == 5'd12 || pos_reg == 5'd15
                                            || pos_reg == 5'd18)
                                        begin
                                            fr_weight = (pos_reg == 5'd12) ? csvp_pkg::SEC_PER_HOUR
                                                      : (pos_reg == 5'd15) ? csvp_pkg::SEC_PER_MIN
                                                      : 12'd1;
                                            whole_next = whole_reg
                                                       + 64'(fr[6:0] * fr_weight);
                                            frac_next  = 64'd0;
                                        end
                                        else
                                        begin
                                            frac_next = fr;
                                        end
                                    end
                                end
                                5'd13, 5'd16:
                                begin
                                    failed_next = (tok_reg.cls != csvp_pkg::CH_COLON);
                                end
                                default:
                                begin
                                    failed_next = 1'b1;
                                end
                            endcase
                        end
                        else if (mode_reg == csvp_pkg::MODE_FRAC)
                        begin
                            if (is_digit)
                            begin
                                failed_next = 1'b0;
                                if (cnt_reg < 4'(csvp_pkg::FRACTION_DIGITS))
                                begin
                                    frac_next = (frac_reg << 3) + (frac_reg << 1) + {60'd0, d};
                                    cnt_next  = cnt_reg + 4'd1;
                                end
                            end
                            else if ((tok_reg.cls == csvp_pkg::CH_PLUS
                                      || tok_reg.cls == csvp_pkg::CH_MINUS)
                                     && month_reg != 4'd0)
                            begin
                                mode_next   = csvp_pkg::MODE_ZONE;
                                pv_next     = 64'd1;
                                failed_next = 1'b0;
                            end
                        end
                        else
                        begin
                            // zone offset: content ignored, colon third
                            if (pv_reg < 64'd6
                                && ((pv_reg == 64'd3) ? (tok_reg.cls == csvp_pkg::CH_COLON)
                                                      : is_digit))
                            begin
                                pv_next     = pv_reg + 64'd1;
                                failed_next = 1'b0;
                            end
                        end
                        if (!failed_next)
                        begin
                            pos_next = pos_bump;
                        end
                    end
                    else
                    begin
                        // price number
                        if (is_digit && mode_reg == csvp_pkg::MODE_NUMBER)
                        begin
                            if (push_ok)
                            begin
                                whole_next = wide[63:0];
                                pos_next   = pos_bump;
                            end
                            else
                            begin
                                failed_next = 1'b1;
                            end
                        end
                        else if (is_digit)
                        begin
                            div_n_next = pv_reg;
                            div_r_next = 4'd0;
                            div_q_next = 64'd0;
                            step_next  = 4'd0;
                            state_next = csvp_pkg::ST_DIV;
                        end
                        else if (tok_reg.cls == csvp_pkg::CH_DOT
                                 && mode_reg == csvp_pkg::MODE_NUMBER)
                        begin
                            mode_next = csvp_pkg::MODE_FRAC;
                            pos_next  = pos_bump;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                end
            end

            csvp_pkg::ST_DIV:
            begin
                // place value divided by ten, one nibble a step
                t8     = {div_r_reg, div_n_reg[63:60]};
                t_mul  = t8 * csvp_pkg::TEN_RECIP;
                qd     = t_mul[csvp_pkg::TEN_SHIFT +: 4];
                div_r_next = 4'(t8 - 8'(qd * 4'd10));
                quo        = {div_q_reg[59:0], qd};
                div_q_next = quo;
                div_n_next = div_n_reg << 4;
                step_next  = step_reg + 4'd1;
                if (step_reg == csvp_pkg::DIV_LAST)
                begin
                    pv_next    = quo;
                    state_next = tok_close ? csvp_pkg::ST_CLOSE : csvp_pkg::ST_IDLE;
                    if (quo == 64'd0)
                    begin
                        if (field_reg == 3'd5)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            pos_next = pos_bump;
                        end
                    end
                    else
                    begin
                        dq_mul    = {4'd0, quo} * {64'd0, d};
                        frac_next = frac_reg + dq_mul[63:0];
                        pos_next  = pos_bump;
                    end
                end
            end

            csvp_pkg::ST_DATE:
            begin
                yy = {1'b0, year_reg} + 15'd400 - ((month_reg <= 4'd2) ? 15'd1 : 15'd0);
                step_next = step_reg + 4'd1;
                case (step_reg[2:0])
                    3'd0:
                    begin
                        yy_mul     = yy * csvp_pkg::YEAR_RECIP;
                        era_q_next = yy_mul[csvp_pkg::YEAR_SHIFT +: 5];
                    end
                    3'd1:
                    begin
                        yoe_next = 9'(yy - 15'(era_q_reg * csvp_pkg::YEARS_PER_ERA));
                    end
                    3'd2:
                    begin
                        cent_mul = yoe_reg * csvp_pkg::CENT_RECIP;
                        doe_sum  = 18'(yoe_reg * csvp_pkg::DAYS_PER_YEAR)
                                 + 18'(yoe_reg >> 2)
                                 - 18'(cent_mul[13:csvp_pkg::CENT_SHIFT])
                                 + 18'(csvp_pkg::doy_base(month_reg))
                                 + 18'(day_reg) - 18'd1;
                        doe_next = doe_sum;
                    end
                    3'd3:
                    begin
                        era       = {27'd0, era_q_reg} - 32'd1;
                        days_next = era * csvp_pkg::DAYS_PER_ERA + {14'd0, doe_reg}
                                  - csvp_pkg::EPOCH_DAYS;
                    end
                    default:
                    begin
                        whole_next = {{32{days_reg[31]}}, days_reg} * csvp_pkg::SEC_PER_DAY;
                        state_next = tok_close ? csvp_pkg::ST_CLOSE : csvp_pkg::ST_IDLE;
                    end
                endcase
            end

            csvp_pkg::ST_FRAC:
            begin
                pw          = csvp_pkg::pow10(4'(csvp_pkg::FRACTION_DIGITS) - cnt_reg);
                frac_scaled = frac_reg[29:0] * pw[29:0];
                fadd_next   = {4'd0, frac_scaled};
                neg_next    = whole_reg[63];
                mul_a_next  = whole_reg[63] ? (64'd0 - whole_reg) : whole_reg;
                mul_b_next  = {20'd0, cfg.ts_scale};
                kind_next   = csvp_pkg::FIN_STAMP;
                acc_next    = 70'd0;
                big_next    = 1'b0;
                step_next   = 4'd0;
                state_next  = csvp_pkg::ST_MUL;
            end

            csvp_pkg::ST_MUL:
            begin
                // product built from the scale's top nibble down
                part     = {6'd0, mul_a_reg} * {66'd0, mul_b_reg[59:56]};
                acc_next = (acc_reg << 4) + part;
                big_next = big_reg || (acc_next[69:65] != 5'd0);
                mul_b_next = mul_b_reg << 4;
                step_next  = step_reg + 4'd1;
                if (step_reg == csvp_pkg::MUL_LAST)
                begin
                    state_next = csvp_pkg::ST_FINISH;
                end
            end

            csvp_pkg::ST_FINISH:
            begin
                prod = acc_reg[65:0];
                if (kind_reg == csvp_pkg::FIN_STAMP)
                begin
                    lim    = neg_reg ? (csvp_pkg::TOP64 + {1'b0, fadd_reg})
                                     : ({1'b0, csvp_pkg::MAX63} - {1'b0, fadd_reg});
                    fin_ok = !big_reg && (prod <= {1'b0, lim});
                    res    = neg_reg ? (fadd_reg - prod[63:0]) : (prod[63:0] + fadd_reg);
                end
                else
                begin
                    psum   = {1'b0, prod} + {3'd0, fadd_reg};
                    fin_ok = !big_reg && (psum <= {3'd0, csvp_pkg::MAX63});
                    res    = psum[63:0];
                end
                if (fin_ok)
                begin
                    store_we      = 1'b1;
                    store_val     = res;
                    parsed_next   = parsed_reg + 3'd1;
                    start_fld     = 1'b1;
                    start_fld_num = (kind_reg == csvp_pkg::FIN_VOL) ? 3'd6 : field_reg + 3'd1;
                end
                else
                begin
                    failed_next = 1'b1;
                end
                state_next = closing_reg ? csvp_pkg::ST_CLOSE2
                           : (tok_close ? csvp_pkg::ST_CLOSE : csvp_pkg::ST_IDLE);
            end

            csvp_pkg::ST_CLOSE:
            begin
                if (in_header_reg)
                begin
                    in_header_next = tok_reg.eod ? cfg.skip_header : 1'b0;
                    start_line     = 1'b1;
                    state_next     = csvp_pkg::ST_IDLE;
                end
                else if (!failed_reg && field_reg == 3'd5)
                begin
                    if (pos_reg == 5'd0)
                    begin
                        failed_next = 1'b1;
                        state_next  = csvp_pkg::ST_CLOSE2;
                    end
                    else
                    begin
                        closing_next = 1'b1;
                        mul_a_next   = whole_reg;
                        mul_b_next   = cfg.vol_scale;
                        fadd_next    = frac_reg;
                        kind_next    = csvp_pkg::FIN_VOL;
                        acc_next     = 70'd0;
                        big_next     = 1'b0;
                        step_next    = 4'd0;
                        state_next   = csvp_pkg::ST_MUL;
                    end
                end
                else
                begin
                    state_next = csvp_pkg::ST_CLOSE2;
                end
            end

            csvp_pkg::ST_CLOSE2:
            begin
                if (!(emit && out_valid_reg && !bar.ready))
                begin
                    load_out     = emit;
                    start_line   = 1'b1;
                    closing_next = 1'b0;
                    if (tok_reg.eod)
                    begin
                        in_header_next = cfg.skip_header;
                    end
                    state_next = csvp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = csvp_pkg::ST_IDLE;
            end
        endcase

        if (start_line)
        begin
            parsed_next   = 3'd0;
            failed_next   = 1'b0;
            start_fld     = 1'b1;
            start_fld_num = 3'd0;
        end
        if (start_fld)
        begin
            field_next = start_fld_num;
            pos_next   = 5'd0;
            mode_next  = csvp_pkg::MODE_NUMBER;
            whole_next = 64'd0;
            frac_next  = 64'd0;
            cnt_next   = 4'd0;
            year_next  = 14'd0;
            month_next = 4'd0;
            day_next   = 5'd0;
            if (start_fld_num >= 3'd1 && start_fld_num <= 3'd4)
            begin
                pv_next = {4'd0, cfg.price_scale};
            end
            else if (start_fld_num == 3'd5)
            begin
                pv_next = {4'd0, cfg.vol_scale};
            end
            else
            begin
                pv_next = 64'd0;
            end
        end
        if (hdr_load)
        begin
            in_header_next = hdr_value;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !bar.ready;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csvp_pkg::ST_IDLE;
            in_header_reg <= 1'b1;
            field_reg     <= 3'd0;
            pos_reg       <= 5'd0;
            mode_reg      <= csvp_pkg::MODE_NUMBER;
            whole_reg     <= 64'd0;
            frac_reg      <= 64'd0;
            pv_reg        <= 64'd0;
            cnt_reg       <= 4'd0;
            year_reg      <= 14'd0;
            month_reg     <= 4'd0;
            day_reg       <= 5'd0;
            parsed_reg    <= 3'd0;
            failed_reg    <= 1'b0;
            closing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_header_reg <= in_header_next;
            field_reg     <= field_next;
            pos_reg       <= pos_next;
            mode_reg      <= mode_next;
            whole_reg     <= whole_next;
            frac_reg      <= frac_next;
            pv_reg        <= pv_next;
            cnt_reg       <= cnt_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            parsed_reg    <= parsed_next;
            failed_reg    <= failed_next;
            closing_reg   <= closing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg   <= tok_next;
        kind_reg  <= kind_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        acc_reg   <= acc_next;
        big_reg   <= big_next;
        step_reg  <= step_next;
        fadd_reg  <= fadd_next;
        neg_reg   <= neg_next;
        div_r_reg <= div_r_next;
        div_n_reg <= div_n_next;
        div_q_reg <= div_q_next;
        era_q_reg <= era_q_next;
        yoe_reg   <= yoe_next;
        doe_reg   <= doe_next;
        days_reg  <= days_next;
        if (store_we && field_reg < 3'd6)
        begin
            store_reg[field_reg] <= store_val;
        end
        if (load_out)
        begin
            out_stamp_reg    <= store_reg[0];
            out_price_reg[0] <= store_reg[1][62:0];
            out_price_reg[1] <= store_reg[2][62:0];
            out_price_reg[2] <= store_reg[3][62:0];
            out_price_reg[3] <= store_reg[4][62:0];
            out_vol_reg      <= store_reg[5][62:0];
        end
    end

    assign bar.valid         = out_valid_reg;
    assign bar.stamp         = $signed(out_stamp_reg);
    assign bar.open_price    = out_price_reg[0];
    assign bar.high_price    = out_price_reg[1];
    assign bar.low_price     = out_price_reg[2];
    assign bar.close_price   = out_price_reg[3];
    assign bar.volume_amount = out_vol_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || bar.ready))
        else $error("row loaded over a result not yet taken");

    a_pop_consume: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == csvp_pkg::ST_CONSUME))
        else $error("popped word not consumed");

    a_parsed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (parsed_reg <= 3'd6) && (field_reg <= 3'd6))
        else $error("field count out of range");

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (failed_reg && state_reg != csvp_pkg::ST_CLOSE && state_reg != csvp_pkg::ST_CLOSE2)
        |=> failed_reg)
        else $error("row failure cleared before line end");

endmodule

// ----- rtl/core/csv_price_bar_row_parser.sv -----
// ----------------------------------------------------------------------------
// csv_price_bar_row_parser
// CSV price bar parser: text bytes in, one bar record out per good line.
// ----------------------------------------------------------------------------
// text: one byte per word with an end_of_data mark on the last byte. A newline
//   or the end_of_data byte closes a line; a bar word goes out on bar only when
//   the timestamp, four prices and volume all parsed.
// cfg: register index and data; 0 timestamp_scale, 1 volume_scale,
//   2 price_scale, 3 skip_header (also rearms header skipping). Writes are
//   taken at once and must come while the parser is idle.
// Structure: a classifier stage and a four-word queue feed the parse engine.
//   Each byte passes the engine's idle and consume states. A price or volume
//   fraction digit adds a serial divide of the place value by ten, four bits
//   a cycle. A field end adds the serial scale multiply, four bits a cycle; a
//   date day digit adds the calendar arithmetic; a line end adds the close
//   states, and the bar word is loaded after the volume multiply.
// Reset: registers take their defaults, the first line is treated as header.
// A stalled bar output holds the engine at line end; the queue and the
//   classifier keep taking bytes until they fill.
// ----------------------------------------------------------------------------
module csv_price_bar_row_parser
(
    input  logic        clk,
    input  logic        rst_n,
    csvp_text_if.sink   text,
    csvp_bar_if.source  bar,
    csvp_cfg_if.sink    cfg
);

    csvp_pkg::cfg_t    cfg_reg;
    csvp_pkg::cfg_t    cfg_next;
    logic              cfg_take;
    logic              hdr_load;
    logic              tok_valid;
    csvp_pkg::token_t  tok;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    csvp_pkg::token_t  head;

    assign cfg.ready = 1'b1;
    assign cfg_take  = cfg.valid && cfg.ready;
    assign hdr_load  = cfg_take && (cfg.index == csvp_pkg::CFG_SKIP_HEADER);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_take)
        begin
            case (cfg.index)
                csvp_pkg::CFG_TS_SCALE:    cfg_next.ts_scale    = cfg.data[39:0];
                csvp_pkg::CFG_VOL_SCALE:   cfg_next.vol_scale   = cfg.data[59:0];
                csvp_pkg::CFG_PRICE_SCALE: cfg_next.price_scale = cfg.data[59:0];
                csvp_pkg::CFG_SKIP_HEADER: cfg_next.skip_header = cfg.data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ts_scale    <= 40'd1000000;
            cfg_reg.vol_scale   <= 60'd1000000;
            cfg_reg.price_scale <= 60'd1000000;
            cfg_reg.skip_header <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    csvp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text),
        .tok_valid (tok_valid),
        .tok       (tok),
        .q_full    (q_full)
    );

    csvp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (tok_valid),
        .push_tok (tok),
        .full     (q_full),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty)
    );

    csvp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .hdr_load  (hdr_load),
        .hdr_value (cfg.data[0]),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .bar       (bar)
    );

endmodule
